### hw/rtl/stse_pkg.sv
`timescale 1ns / 1ps

package stse_pkg;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 5;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 6;
    localparam int POS_W   = 5;

    // widest table address the block supports (4096 entries)
    localparam int MAX_ADDR_W = 12;

    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BSEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LSEARCH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BPROBE,
        ST_BCHECK,
        ST_LSCAN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic                  we;
        logic [MAX_ADDR_W-1:0] waddr;
        logic                  re;
        logic [MAX_ADDR_W-1:0] raddr;
    } mem_cmd_t;

endpackage

### hw/rtl/stse_if.sv
`timescale 1ns / 1ps

interface stse_req_if import stse_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] entry_value;
    logic signed [VAL_W-1:0] search_key;

    modport source (
        output valid, cmd, entry_index, entry_value, search_key,
        input  ready
    );

    modport sink (
        input  valid, cmd, entry_index, entry_value, search_key,
        output ready
    );
endinterface

interface stse_rsp_if import stse_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] position;

    modport source (
        output valid, found, position,
        input  ready
    );

    modport sink (
        input  valid, found, position,
        output ready
    );
endinterface

### hw/rtl/stse_table.sv
`timescale 1ns / 1ps

module stse_table import stse_pkg::*; #(
    parameter int DEPTH = 32
) (
    input  logic                    clk,
    input  mem_cmd_t                mem_cmd,
    input  logic [VAL_W-1:0]        wdata,
    output logic signed [VAL_W-1:0] rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_cmd.we)
        begin
            mem[mem_cmd.waddr[AW-1:0]] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_cmd.re)
        begin
            rdata_reg <= mem[mem_cmd.raddr[AW-1:0]];
        end
    end

    assign rdata = $signed(rdata_reg);

endmodule

### hw/rtl/stse_ctrl.sv
`timescale 1ns / 1ps

module stse_ctrl import stse_pkg::*; #(
    parameter int DEPTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [CNT_W-1:0]        entries_in_use,
    stse_req_if.sink                req,
    stse_rsp_if.source              rsp,
    output mem_cmd_t                mem_cmd,
    output logic [VAL_W-1:0]        wdata,
    input  logic signed [VAL_W-1:0] rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    state_t state_reg, state_next;

    logic [CW-1:0]           lo_reg, lo_next;
    logic [CW-1:0]           lim_reg, lim_next;
    logic [AW-1:0]           mid_reg, mid_next;
    logic signed [VAL_W-1:0] key_reg, key_next;
    logic [CW-1:0]           issue_reg, issue_next;
    logic [AW-1:0]           cmp_reg, cmp_next;
    logic                    pend_reg, pend_next;
    logic                    hit_reg, hit_next;
    logic [AW-1:0]           pos_reg, pos_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    out_found_reg, out_found_next;
    logic [POS_W-1:0]        out_pos_reg, out_pos_next;

    logic [CW-1:0]           cnt;
    logic [CW:0]             mid_sum;
    logic [AW-1:0]           mid;
    logic                    accept;
    logic                    idx_ok;

    // clamp the count to the table depth
    always_comb
    begin
        if (32'(entries_in_use) > DEPTH)
        begin
            cnt = CW'(DEPTH);
        end
        else
        begin
            cnt = CW'(entries_in_use);
        end
    end

    assign mid_sum = {1'b0, lo_reg} + {1'b0, lim_reg} - (CW + 1)'(1);
    assign mid     = AW'(mid_sum >> 1);
    assign idx_ok  = 32'(req.entry_index) < DEPTH;

    assign req.ready    = (state_reg == ST_IDLE);
    assign accept       = req.valid && req.ready;
    assign rsp.valid    = out_valid_reg;
    assign rsp.found    = out_found_reg;
    assign rsp.position = out_pos_reg;
    assign wdata        = req.entry_value;

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        lim_next       = lim_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        issue_next     = issue_reg;
        cmp_next       = cmp_reg;
        pend_next      = pend_reg;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_pos_next   = out_pos_reg;

        mem_cmd.we     = 1'b0;
        mem_cmd.waddr  = MAX_ADDR_W'(req.entry_index);
        mem_cmd.re     = 1'b0;
        mem_cmd.raddr  = '0;

        // drop the result beat once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next   = req.search_key;
                    lo_next    = '0;
                    lim_next   = cnt;
                    issue_next = '0;
                    pend_next  = 1'b0;
                    case (req.cmd)
                        CMD_WRITE:
                        begin
                            mem_cmd.we = idx_ok;
                        end
                        CMD_BSEARCH:
                        begin
                            state_next = ST_BPROBE;
                        end
                        CMD_LSEARCH:
                        begin
                            state_next = ST_LSCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_BPROBE:
            begin
                if (lo_reg >= lim_reg)
                begin
                    hit_next   = 1'b0;
                    pos_next   = '0;
                    state_next = ST_RESULT;
                end
                else
                begin
                    mem_cmd.re    = 1'b1;
                    mem_cmd.raddr = MAX_ADDR_W'(mid);
                    mid_next      = mid;
                    state_next    = ST_BCHECK;
                end
            end

            ST_BCHECK:
            begin
                if (rdata == key_reg)
                begin
                    hit_next   = 1'b1;
                    pos_next   = mid_reg;
                    state_next = ST_RESULT;
                end
                else
                begin
                    if (rdata > key_reg)
                    begin
                        lim_next = CW'(mid_reg);
                    end
                    else
                    begin
                        lo_next = CW'(mid_reg) + CW'(1);
                    end
                    state_next = ST_BPROBE;
                end
            end

            ST_LSCAN:
            begin
                // compare last cycle's read while issuing the next one
                if (pend_reg && (rdata == key_reg))
                begin
                    hit_next   = 1'b1;
                    pos_next   = cmp_reg;
                    state_next = ST_RESULT;
                end
                else if (issue_reg < cnt)
                begin
                    mem_cmd.re    = 1'b1;
                    mem_cmd.raddr = MAX_ADDR_W'(issue_reg);
                    cmp_next      = AW'(issue_reg);
                    pend_next     = 1'b1;
                    issue_next    = issue_reg + CW'(1);
                end
                else
                begin
                    hit_next   = 1'b0;
                    pos_next   = '0;
                    state_next = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = hit_reg;
                    out_pos_next   = POS_W'(pos_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        lim_reg       <= lim_next;
        mid_reg       <= mid_next;
        key_reg       <= key_next;
        issue_reg     <= issue_next;
        cmp_reg       <= cmp_next;
        hit_reg       <= hit_next;
        pos_reg       <= pos_next;
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
    end

endmodule

### hw/rtl/sorted_table_search_engine.sv
`timescale 1ns / 1ps

// Table of DEPTH signed 32-bit entries held in one synchronous RAM with a
// single registered read port. A write beat stores one entry and returns
// nothing; writes to an index at or above DEPTH are dropped. A binary search
// beat probes (low+high)/2 over the first entries_in_use entries (clamped to
// DEPTH), reading each probe in ST_BPROBE and comparing it in ST_BCHECK; a
// linear search beat streams one read per cycle from index 0 and compares
// the previous read in the same cycle.
// Every search returns one beat with found and position (position is 0 on a
// miss). One item is worked at a time; a finished result sits in an output
// register so the next item is accepted while it waits. Write
// entries_in_use only while the block is idle. Entries must be written
// before a search reads them.

module sorted_table_search_engine import stse_pkg::*; #(
    parameter int DEPTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    stse_req_if.sink         req,
    stse_rsp_if.source       rsp
);

    logic [CNT_W-1:0]        entries_in_use_reg;
    mem_cmd_t                mem_cmd;
    logic [VAL_W-1:0]        wdata;
    logic signed [VAL_W-1:0] rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= '0;
        end
        else if (cfg_we)
        begin
            entries_in_use_reg <= cfg_wdata;
        end
    end

    stse_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .entries_in_use (entries_in_use_reg),
        .req            (req),
        .rsp            (rsp),
        .mem_cmd        (mem_cmd),
        .wdata          (wdata),
        .rdata          (rdata)
    );

    stse_table #(
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .mem_cmd (mem_cmd),
        .wdata   (wdata),
        .rdata   (rdata)
    );

endmodule

### sim/tb_sorted_table_search_engine.sv
`timescale 1ns / 1ps

module tb_sorted_table_search_engine;
    import stse_pkg::*;

    localparam int TABLE_DEPTH  = 32;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 48;
    localparam int HOLD_OFF_LEN = 400;

    localparam logic [CMD_W-1:0]        CMD_UNUSED = 2'd3;
    localparam logic signed [VAL_W-1:0] VAL_MIN    = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX    = 32'sh7fff_ffff;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } answer_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    stse_req_if req_bus ();
    stse_rsp_if rsp_bus ();

    sorted_table_search_engine #(
        .DEPTH (TABLE_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_bus),
        .rsp       (rsp_bus)
    );

    // shadow copy of the table and the entries_in_use register
    logic signed [VAL_W-1:0] shadow_table [TABLE_DEPTH];
    logic [CNT_W-1:0]        shadow_count;
    answer_t                 pending_answers [$];

    int mismatches;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[sorted_table_search_engine] ERROR");
        $finish;
    end

    function automatic int active_entries();
        if (shadow_count > TABLE_DEPTH)
            return TABLE_DEPTH;
        return int'(shadow_count);
    endfunction

    function automatic answer_t predict_binary(logic signed [VAL_W-1:0] key);
        answer_t a;
        int      lo;
        int      hi;
        int      mid;
        a  = '0;
        lo = 0;
        hi = active_entries() - 1;
        while (hi >= lo)
        begin
            mid = (hi + lo) / 2;
            if (shadow_table[mid] == key)
            begin
                a.found    = 1'b1;
                a.position = mid[POS_W-1:0];
                return a;
            end
            if (shadow_table[mid] > key)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return a;
    endfunction

    function automatic answer_t predict_linear(logic signed [VAL_W-1:0] key);
        answer_t a;
        int      n;
        a = '0;
        n = active_entries();
        for (int i = 0; i < n; i++)
        begin
            if (shadow_table[i] == key)
            begin
                a.found    = 1'b1;
                a.position = i[POS_W-1:0];
                return a;
            end
        end
        return a;
    endfunction

    task automatic record_beat(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                               logic signed [VAL_W-1:0] val,
                               logic signed [VAL_W-1:0] key);
        case (cmd)
            CMD_WRITE:   shadow_table[idx] = val;
            CMD_BSEARCH: pending_answers.push_back(predict_binary(key));
            CMD_LSEARCH: pending_answers.push_back(predict_linear(key));
            default:     ;
        endcase
    endtask

    // called and returns at a falling edge; valid stays high on return
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                             logic signed [VAL_W-1:0] val,
                             logic signed [VAL_W-1:0] key);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.cmd         <= cmd;
        req_bus.entry_index <= idx;
        req_bus.entry_value <= val;
        req_bus.search_key  <= key;
        do
            @(posedge clk);
        while (!req_bus.ready);
        record_beat(cmd, idx, val, key);
        @(negedge clk);
    endtask

    task automatic send_write(logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] val);
        send_item(CMD_WRITE, idx, val, $urandom);
    endtask

    task automatic send_search(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] key);
        send_item(cmd, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), $urandom, key);
    endtask

    task automatic send_unused();
        send_item(CMD_UNUSED, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), $urandom, $urandom);
    endtask

    // drop valid, drain every answer, then let a trailing write finish
    task automatic idle_block();
        req_bus.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_entries_in_use(logic [CNT_W-1:0] count);
        idle_block();
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(negedge clk);
        cfg_we       <= 1'b0;
        shadow_count = count;
    endtask

    task automatic fill_sorted_table(int step_max, bit pin_extremes);
        longint                  cur;
        logic signed [VAL_W-1:0] v;
        if (step_max >= (1 << 26))
            cur = longint'(VAL_MIN) + longint'($urandom_range(0, step_max));
        else
            cur = longint'($signed($urandom));
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (cur > longint'(VAL_MAX))
                cur = longint'(VAL_MAX);
            v = cur[VAL_W-1:0];
            if (pin_extremes && i == 0)
                v = VAL_MIN;
            if (pin_extremes && i == TABLE_DEPTH - 1)
                v = VAL_MAX;
            send_write(i[IDX_W-1:0], v);
            cur = cur + longint'($urandom_range(0, step_max));
        end
    endtask

    function automatic logic signed [VAL_W-1:0] pick_key();
        int                      roll;
        logic signed [VAL_W-1:0] near;
        roll = $urandom_range(0, 99);
        near = shadow_table[$urandom_range(0, TABLE_DEPTH - 1)];
        if (roll < 50)
            return near;
        if (roll < 70)
            return $urandom_range(0, 1) ? near + 1 : near - 1;
        if (roll < 80)
            return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
        return $urandom;
    endfunction

    initial
    begin
        answer_t got;
        answer_t want;
        mismatches = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_bus.valid && rsp_bus.ready)
            begin
                got.found    = rsp_bus.found;
                got.position = rsp_bus.position;
                if (pending_answers.size() == 0)
                begin
                    $display("%0t unexpected beat: found %0b position %0d",
                             $time, got.found, got.position);
                    mismatches++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (got.found !== want.found)
                    begin
                        $display("%0t found: expected %0b actual %0b",
                                 $time, want.found, got.found);
                        mismatches++;
                    end
                    if (got.position !== want.position)
                    begin
                        $display("%0t position: expected %0d actual %0d",
                                 $time, want.position, got.position);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        rsp_bus.ready = 1'b0;
        hold_cycles   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                rsp_bus.ready <= 1'b0;
                hold_cycles--;
            end
            else
                rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic test_empty_table();
        set_entries_in_use(0);
        send_search(CMD_BSEARCH, 0);
        send_search(CMD_LSEARCH, VAL_MIN);
    endtask

    task automatic test_known_table();
        logic signed [VAL_W-1:0] v;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (i == 0)
                v = VAL_MIN;
            else if (i == 16)
                v = 500;
            else if (i == 30)
                v = VAL_MAX - 1;
            else if (i == 31)
                v = VAL_MAX;
            else
                v = -1000 + 100 * i;
            send_write(i[IDX_W-1:0], v);
        end
        set_entries_in_use(CNT_W'(TABLE_DEPTH));
        send_search(CMD_BSEARCH, VAL_MIN);
        send_search(CMD_BSEARCH, VAL_MAX);
        send_search(CMD_BSEARCH, 500);
        send_search(CMD_BSEARCH, -300);
        send_search(CMD_BSEARCH, 1);
        send_search(CMD_BSEARCH, VAL_MAX - 1);
        send_unused();
        send_search(CMD_LSEARCH, 500);
        send_search(CMD_LSEARCH, VAL_MAX);
        send_search(CMD_LSEARCH, VAL_MIN);
        send_search(CMD_LSEARCH, 1);
    endtask

    task automatic test_count_limits();
        set_entries_in_use(6'd63);
        send_search(CMD_BSEARCH, VAL_MAX);
        send_search(CMD_LSEARCH, VAL_MAX);
        set_entries_in_use(CNT_W'(TABLE_DEPTH + 1));
        send_search(CMD_LSEARCH, VAL_MAX - 1);
        set_entries_in_use(1);
        send_search(CMD_BSEARCH, VAL_MIN);
        send_search(CMD_BSEARCH, -900);
        send_search(CMD_LSEARCH, VAL_MIN);
        send_search(CMD_LSEARCH, -900);
    endtask

    task automatic test_unsorted_probe();
        set_entries_in_use(CNT_W'(TABLE_DEPTH));
        send_write(5, VAL_MAX);
        send_search(CMD_BSEARCH, -600);
        send_search(CMD_BSEARCH, 1500);
        send_search(CMD_LSEARCH, VAL_MAX);
    endtask

    // hold the response side while requests keep coming
    task automatic test_backpressure();
        set_entries_in_use(CNT_W'(TABLE_DEPTH));
        hold_cycles = HOLD_OFF_LEN;
        for (int i = 0; i < 16; i++)
            send_search($urandom_range(0, 1) ? CMD_LSEARCH : CMD_BSEARCH, pick_key());
        idle_block();
    endtask

    task automatic test_random_traffic(int rounds, int items_per_round);
        int               counted;
        int               roll;
        logic [CNT_W-1:0] count;
        for (int r = 0; r < rounds; r++)
        begin
            case ($urandom_range(0, 7))
                0:       count = 0;
                1:       count = 1;
                2:       count = CNT_W'(TABLE_DEPTH);
                3:       count = CNT_W'(TABLE_DEPTH + 1);
                4:       count = 6'd63;
                5:       count = CNT_W'(TABLE_DEPTH - 1);
                default: count = CNT_W'($urandom_range(0, 63));
            endcase
            set_entries_in_use(count);
            if ($urandom_range(0, 9) == 0)
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    send_write(i[IDX_W-1:0], $urandom);
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0:       fill_sorted_table(2, $urandom_range(0, 1));
                    1:       fill_sorted_table(1000, $urandom_range(0, 1));
                    2:       fill_sorted_table(1 << 20, $urandom_range(0, 1));
                    3:       fill_sorted_table(1 << 26, $urandom_range(0, 1));
                    default: fill_sorted_table(1 << 27, $urandom_range(0, 1));
                endcase
            end
            counted = 0;
            while (counted < items_per_round)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    send_unused();
                else
                begin
                    if (roll < 12)
                        send_write(IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), $urandom);
                    else if (roll < 56)
                        send_search(CMD_BSEARCH, pick_key());
                    else
                        send_search(CMD_LSEARCH, pick_key());
                    counted++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_bus.valid       = 1'b0;
        req_bus.cmd         = CMD_WRITE;
        req_bus.entry_index = '0;
        req_bus.entry_value = '0;
        req_bus.search_key  = '0;
        shadow_count        = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            shadow_table[i] = '0;
        send_idle_pct = 38;
        recv_idle_pct = 59;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_table();
        test_known_table();
        test_count_limits();
        test_unsorted_probe();
        test_backpressure();
        test_random_traffic(4, 44);

        send_idle_pct = 59;
        recv_idle_pct = 38;
        test_random_traffic(5, 44);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(5, 44);

        idle_block();
        if (mismatches == 0)
            $display("[sorted_table_search_engine] OK");
        else
            $display("[sorted_table_search_engine] ERROR");
        $finish;
    end

endmodule

### sorted_table_search_engine.f
hw/rtl/stse_pkg.sv
hw/rtl/stse_if.sv
hw/rtl/stse_table.sv
hw/rtl/stse_ctrl.sv
hw/rtl/sorted_table_search_engine.sv
sim/tb_sorted_table_search_engine.sv
